[src/apr_pkg.sv]
// Shared types and constants for the aging page-replacement engine.
package apr_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic match;
        logic less;
    } t_cmp_res;

    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam int          CFG_BITS      = 5;
    localparam logic [4:0]  CFG_FRAMES_RST = 5'd16;
    localparam int          SLOT_OUT_BITS = 4;

endpackage

[src/apr_slot_mem.sv]
// Slot store: page number and age per frame, one write and one registered read per cycle.
module apr_slot_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/apr_cmp_unit.sv]
// Shared compare and shift unit: page match, age compare, age shift.
module apr_cmp_unit #(
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 32
) (
    input  logic [PAGE_BITS-1:0] i_page_a,
    input  logic [PAGE_BITS-1:0] i_page_b,
    input  logic [AGE_BITS-1:0]  i_age_a,
    input  logic [AGE_BITS-1:0]  i_age_b,
    output apr_pkg::t_cmp_res    o_res,
    output logic [AGE_BITS-1:0]  o_age_shr
);
    import apr_pkg::*;

    always_comb begin
        o_res.match = (i_page_a == i_page_b);
        o_res.less  = (i_age_a < i_age_b);
        o_age_shr   = i_age_a >> 1;
    end

endmodule

[src/aging_page_replacement.sv]
// Top level of the aging page-replacement engine.
//
// Input channel: i_valid / o_stall carry one request (i_req_type, i_page_number).
// A page access looks the page up among all frames, then either refreshes its
// age on a hit, fills the lowest free frame below the frame limit, or evicts
// the valid frame with the smallest age. A period tick ages every valid frame
// not referenced in the period and clears all reference marks.
// Output channel: o_valid / i_stall carry one result per request.
// Frame limit: written through i_cfg_we / i_cfg_wdata, which the user must
// only drive while the engine is idle; the block itself leaves this unchecked.
// Timing: each request walks all FRAMES slots through the one-read-port slot
// store, one slot read per cycle; the scan ends once the registered read of the
// last slot is evaluated; an update state follows, and o_valid rises in S_OUT.
// The next request is taken only after the result transfers and the engine is
// back in idle, so requests do not overlap.
// A stalled result holds in the output register; o_stall stays high until
// it transfers. Reset empties all frames and sets the frame limit to 16.
module aging_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [apr_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [PAGE_BITS-1:0]          i_page_number,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [apr_pkg::SLOT_OUT_BITS-1:0] o_frame_slot,
    output logic                          o_evicted_valid,
    output logic [PAGE_BITS-1:0]          o_evicted_page
);
    import apr_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam int LW = $clog2(FRAMES + 1);
    localparam int EW = PAGE_BITS + AGE_BITS;
    localparam logic [AGE_BITS-1:0] AGE_TOP  = {1'b1, {(AGE_BITS-1){1'b0}}};
    localparam logic [IW-1:0]       LAST_IDX = IW'(FRAMES - 1);

    t_state r_state, n_state;

    logic [CFG_BITS-1:0]  r_cfg;
    logic                 r_is_tick;
    logic [PAGE_BITS-1:0] r_page;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_issue_done;
    logic                 r_pend;
    logic [IW-1:0]        r_pend_idx;
    logic [FRAMES-1:0]    r_valid;
    logic [FRAMES-1:0]    r_ref;

    logic                 r_hit_found;
    logic [IW-1:0]        r_hit_idx;
    logic [AGE_BITS-1:0]  r_hit_age;
    logic                 r_free_found;
    logic [IW-1:0]        r_free_idx;
    logic                 r_min_found;
    logic [IW-1:0]        r_min_idx;
    logic [AGE_BITS-1:0]  r_min_age;
    logic [PAGE_BITS-1:0] r_min_page;

    logic                 r_o_hit;
    logic [IW-1:0]        r_o_slot;
    logic                 r_o_ev_valid;
    logic [PAGE_BITS-1:0] r_o_ev_page;

    logic [LW-1:0]        w_lim;
    logic [EW-1:0]        w_rdata;
    logic [PAGE_BITS-1:0] w_rd_page;
    logic [AGE_BITS-1:0]  w_rd_age;
    logic [AGE_BITS-1:0]  w_age_a;
    logic [AGE_BITS-1:0]  w_shr;
    t_cmp_res             w_cmp;
    logic                 w_pv;
    logic                 w_accept;
    logic                 w_mem_we;
    logic [IW-1:0]        w_mem_waddr;
    logic [EW-1:0]        w_mem_wdata;

    assign w_rd_page = w_rdata[EW-1:AGE_BITS];
    assign w_rd_age  = w_rdata[AGE_BITS-1:0];
    assign w_pv      = r_valid[r_pend_idx];
    assign w_accept  = (r_state == S_IDLE) && i_valid;
    assign w_age_a   = (r_state == S_UPDATE) ? r_hit_age : w_rd_age;

    // Clamp the frame limit to 1..FRAMES.
    always_comb begin
        if (r_cfg == '0) begin
            w_lim = LW'(1);
        end else if (int'(r_cfg) > FRAMES) begin
            w_lim = LW'(FRAMES);
        end else begin
            w_lim = LW'(r_cfg);
        end
    end

    apr_slot_mem #(
        .DEPTH (FRAMES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    apr_cmp_unit #(
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_cmp (
        .i_page_a  (r_page),
        .i_page_b  (w_rd_page),
        .i_age_a   (w_age_a),
        .i_age_b   (r_min_age),
        .o_res     (w_cmp),
        .o_age_shr (w_shr)
    );

    // Slot store write: age-out on a tick scan, refresh or load on update.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_pend_idx;
        w_mem_wdata = {w_rd_page, w_shr};
        if (r_state == S_SCAN) begin
            if (r_pend && r_is_tick && w_pv && !r_ref[r_pend_idx]) begin
                w_mem_we = 1'b1;
            end
        end else if (r_state == S_UPDATE && !r_is_tick) begin
            if (r_hit_found) begin
                w_mem_we    = !r_ref[r_hit_idx];
                w_mem_waddr = r_hit_idx;
                w_mem_wdata = {r_page, w_shr | AGE_TOP};
            end else if (r_free_found) begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_free_idx;
                w_mem_wdata = {r_page, AGE_TOP};
            end else begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_min_idx;
                w_mem_wdata = {r_page, AGE_TOP};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SCAN;
            S_SCAN:   if (r_issue_done && !r_pend) n_state = S_UPDATE;
            S_UPDATE: n_state = S_OUT;
            S_OUT:    if (!i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_OUT:   o_valid = 1'b1;
            default: begin
                o_stall = 1'b1;
                o_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg        <= CFG_FRAMES_RST;
            r_valid      <= '0;
            r_ref        <= '0;
            r_pend       <= 1'b0;
            r_issue_done <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end

            if (w_accept) begin
                r_is_tick    <= (i_req_type == REQ_TICK);
                r_page       <= i_page_number;
                r_rd_idx     <= '0;
                r_issue_done <= 1'b0;
                r_pend       <= 1'b0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
                r_min_found  <= 1'b0;
                r_min_idx    <= '0;
            end

            if (r_state == S_SCAN) begin
                // Issue one slot read a cycle; evaluate the slot read last cycle.
                if (!r_issue_done) begin
                    r_pend     <= 1'b1;
                    r_pend_idx <= r_rd_idx;
                    if (r_rd_idx == LAST_IDX) begin
                        r_issue_done <= 1'b1;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end else begin
                    r_pend <= 1'b0;
                end

                if (r_pend && !r_is_tick) begin
                    if (w_pv && w_cmp.match && !r_hit_found) begin
                        r_hit_found <= 1'b1;
                        r_hit_idx   <= r_pend_idx;
                        r_hit_age   <= w_rd_age;
                    end
                    if (!w_pv && (LW'(r_pend_idx) < w_lim) && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_pend_idx;
                    end
                    if (w_pv && (!r_min_found || w_cmp.less)) begin
                        r_min_found <= 1'b1;
                        r_min_idx   <= r_pend_idx;
                        r_min_age   <= w_rd_age;
                        r_min_page  <= w_rd_page;
                    end
                end
            end

            if (r_state == S_UPDATE) begin
                r_o_hit      <= 1'b0;
                r_o_slot     <= '0;
                r_o_ev_valid <= 1'b0;
                r_o_ev_page  <= '0;
                if (r_is_tick) begin
                    r_ref <= '0;
                end else if (r_hit_found) begin
                    r_ref[r_hit_idx] <= 1'b1;
                    r_o_hit          <= 1'b1;
                    r_o_slot         <= r_hit_idx;
                end else if (r_free_found) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_ref[r_free_idx]   <= 1'b0;
                    r_o_slot            <= r_free_idx;
                end else begin
                    r_valid[r_min_idx] <= 1'b1;
                    r_ref[r_min_idx]   <= 1'b0;
                    r_o_slot           <= r_min_idx;
                    r_o_ev_valid       <= r_min_found;
                    r_o_ev_page        <= r_min_found ? r_min_page : '0;
                end
            end
        end
    end

    assign o_hit           = r_o_hit;
    assign o_frame_slot    = SLOT_OUT_BITS'(r_o_slot);
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_page  = r_o_ev_page;

endmodule

[src/apr_checker.sv]
// Port-level checker for the aging page-replacement engine, bound to the top level.
module apr_checker #(
    parameter int PAGE_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_hit,
    input logic                 o_evicted_valid,
    input logic [PAGE_BITS-1:0] o_evicted_page
);
    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // After a request transfers the engine is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken while busy");

    // No new request is taken while a result waits.
    a_stall_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("ready while result pending");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_evicted_valid)
        else $error("hit reported an eviction");

    // Without an eviction the evicted page reads zero.
    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted_valid |-> o_evicted_page == '0)
        else $error("evicted page set without eviction");

endmodule

bind aging_page_replacement apr_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_apr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_page  (o_evicted_page)
);

[bench/testbench.sv]
// Self-checking testbench for the aging page-replacement engine.
module testbench;
    import apr_pkg::*;

    localparam int          NUM_FRAMES  = 16;
    localparam logic [31:0] AGE_TOP     = 32'h8000_0000;
    localparam int          STALL_LIMIT = 4000;
    localparam int          LONG_HOLD   = 300;
    localparam int          PHASE_ITEMS = 105;

    typedef struct packed {
        logic                     hit;
        logic [SLOT_OUT_BITS-1:0] slot;
        logic                     evicted;
        logic [15:0]              evicted_page;
    } t_replace_res;

    // Frame table mirror: predicts each result and compares it on arrival.
    class frame_table_sb;
        bit                 valid[NUM_FRAMES];
        logic [15:0]        page[NUM_FRAMES];
        logic [31:0]        age[NUM_FRAMES];
        bit                 mark[NUM_FRAMES];
        logic [CFG_BITS-1:0] frames_reg;
        t_replace_res       expected_q[$];
        int                 mismatches;
        int                 hits;
        int                 evictions;
        int                 ticks;
        int                 requests;

        function new();
            for (int i = 0; i < NUM_FRAMES; i++) begin
                valid[i] = 0;
                mark[i]  = 0;
                page[i]  = '0;
                age[i]   = '0;
            end
            frames_reg = CFG_FRAMES_RST;
            mismatches = 0;
            hits       = 0;
            evictions  = 0;
            ticks      = 0;
            requests   = 0;
        endfunction

        function void set_frames(logic [CFG_BITS-1:0] v);
            frames_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic req_type, logic [15:0] pg);
            t_replace_res r;
            int           s;
            int           lim;
            bit           found;
            r     = '0;
            s     = 0;
            found = 0;
            requests++;
            if (req_type == REQ_TICK) begin
                // age every unmarked page, then open a new period
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (valid[i] && !mark[i])
                        age[i] = age[i] >> 1;
                    mark[i] = 0;
                end
                ticks++;
                expected_q.push_back(r);
                return;
            end
            for (int i = 0; i < NUM_FRAMES && !found; i++) begin
                if (valid[i] && page[i] == pg) begin
                    found = 1;
                    s     = i;
                end
            end
            if (found) begin
                if (!mark[s]) begin
                    age[s]  = (age[s] >> 1) | AGE_TOP;
                    mark[s] = 1;
                end
                r.hit  = 1;
                r.slot = s[SLOT_OUT_BITS-1:0];
                hits++;
                expected_q.push_back(r);
                return;
            end
            lim = (frames_reg == 0) ? 1 :
                  (frames_reg > NUM_FRAMES ? NUM_FRAMES : frames_reg);
            for (int i = 0; i < lim && !found; i++) begin
                if (!valid[i]) begin
                    found = 1;
                    s     = i;
                end
            end
            if (!found) begin
                // smallest age among all valid slots, lowest slot on ties
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (valid[i] && (!found || age[i] < age[s])) begin
                        found = 1;
                        s     = i;
                    end
                end
                if (found) begin
                    r.evicted      = 1;
                    r.evicted_page = page[s];
                    evictions++;
                end
            end
            valid[s] = 1;
            page[s]  = pg;
            age[s]   = AGE_TOP;
            mark[s]  = 0;
            r.slot   = s[SLOT_OUT_BITS-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(t_replace_res got);
            t_replace_res want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing outstanding: %s hit=%0b slot=%0d",
                             "unexpected", got.hit, got.slot);
                return;
            end
            want = expected_q.pop_front();
            if (got.hit !== want.hit || got.slot !== want.slot ||
                got.evicted !== want.evicted || got.evicted_page !== want.evicted_page) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: hit %0b/%0b slot %0d/%0d evicted %0b/%0b page %h/%h (exp/got)",
                             want.hit, got.hit, want.slot, got.slot,
                             want.evicted, got.evicted, want.evicted_page, got.evicted_page);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_BITS-1:0]      i_cfg_wdata;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_req_type;
    logic [15:0]              i_page_number;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_hit;
    logic [SLOT_OUT_BITS-1:0] o_frame_slot;
    logic                     o_evicted_valid;
    logic [15:0]              o_evicted_page;

    frame_table_sb sb = new();

    bit          no_idle;
    bit          hold_req;
    int          idle_cycles;
    int          settings_used;
    logic [15:0] pool[24];
    int          pool_size;

    aging_page_replacement uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_page_number  (i_page_number),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_frame_slot   (o_frame_slot),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_page (o_evicted_page)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sample both transfers and run the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result(t_replace_res'{o_hit, o_frame_slot, o_evicted_valid,
                                               o_evicted_page});
            if (i_valid && !o_stall)
                sb.note_request(i_req_type, i_page_number);
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: random stall, plus one long hold-off on request.
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 0;
            end
            n = pick_gap();
            if (n > 0) begin
                i_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall = 1'b0;
        end
    end

    task automatic send_request(logic req_type, logic [15:0] pg);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_req_type    = req_type;
        i_page_number = pg;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic access_page(logic [15:0] pg);
        send_request(REQ_ACCESS, pg);
    endtask

    task automatic period_tick();
        send_request(REQ_TICK, 16'($urandom_range(0, 65535)));
    endtask

    // Drain all outstanding results before touching the frame limit.
    task automatic set_frame_limit(logic [CFG_BITS-1:0] v);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_frames(v);
        settings_used++;
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            period_tick();
        else if (r < 25)
            access_page(16'($urandom_range(0, 65535)));
        else
            access_page(pool[$urandom_range(0, pool_size - 1)]);
    endtask

    initial begin
        int lim;
        int limits[9];
        limits        = '{16, 4, 1, 8, 2, 31, 0, 12, 16};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_req_type    = REQ_ACCESS;
        i_page_number = '0;
        no_idle       = 0;
        hold_req      = 0;
        idle_cycles   = 0;
        settings_used = 1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fills, repeated hits within a period, ticks, at the reset limit
        access_page(16'h0000);
        access_page(16'hFFFF);
        access_page(16'h0000);
        access_page(16'h0000);
        period_tick();
        access_page(16'hFFFF);
        period_tick();
        access_page(16'h1234);

        // lowered limit: evict among all valid slots, including ones above it
        set_frame_limit(5'd2);
        access_page(16'h0ABC);
        access_page(16'h1234);
        access_page(16'h5555);
        period_tick();
        access_page(16'hAAAA);

        // zero limit behaves as one frame
        set_frame_limit(5'd0);
        access_page(16'h0F0F);
        access_page(16'h0ABC);
        access_page(16'h7777);
        period_tick();

        // limit above the frame count saturates
        set_frame_limit(5'd31);
        access_page(16'h8000);
        access_page(16'h0001);
        access_page(16'h7777);
        period_tick();
        period_tick();
        access_page(16'h8000);

        for (int ph = 0; ph < 9; ph++) begin
            set_frame_limit(limits[ph][CFG_BITS-1:0]);
            no_idle   = (ph == 3 || ph == 7);
            lim       = (limits[ph] == 0) ? 1 :
                        (limits[ph] > NUM_FRAMES ? NUM_FRAMES : limits[ph]);
            pool_size = lim + $urandom_range(1, 6);
            for (int k = 0; k < pool_size; k++)
                pool[k] = 16'($urandom_range(0, 65535));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // back up the result side while requests keep coming
                if (ph == 2 && n == 30)
                    hold_req = 1;
                random_request();
            end
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d requests: %0d hits, %0d evictions, %0d ticks",
                 sb.requests, sb.hits, sb.evictions, sb.ticks);
        $display("over %0d frame-limit settings, with random and long result-side stalls",
                 settings_used);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
